// File: rtl/jfd_pkg.sv
package jfd_pkg;

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_WIDE   = 2'd1,
    MODE_MD     = 2'd2,
    MODE_NONE   = 2'd3
  } pad_mode_t;

  localparam int unsigned PAD_W  = 12;
  localparam int unsigned BYTE_W = 8;

  // Previous-byte patterns that mark the extra and the phase frames of a multiplexed pad
  localparam logic [BYTE_W-1:0] MD_EXTRA_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] MD_PHASE_MASK = 8'h30;

  typedef struct packed {
    logic      enable;
    pad_mode_t mode;
    logic      first;
    logic      last;
  } lane_ctrl_t;

  function automatic logic [PAD_W-1:0] db9_remap(input logic [BYTE_W-1:0] b);
    return {6'b0, b[2], b[3], b[7:4]};
  endfunction

  // d is the inverted frame
  function automatic logic [PAD_W-1:0] jamma_pad0(input logic [31:0] d);
    return {d[20], d[21], d[8], d[9], d[23:22], d[11:10], d[15:12]};
  endfunction

  function automatic logic [PAD_W-1:0] jamma_pad1(input logic [31:0] d);
    return {d[24], d[25], d[28], d[29], d[27:26], d[31:30], d[19:16]};
  endfunction

endpackage

// File: rtl/jfd_cfg_if.sv
interface jfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] pad_mode;

  modport source (output valid, output pad_mode, input ready);
  modport sink   (input valid, input pad_mode, output ready);
endinterface

// File: rtl/jfd_frame_if.sv
interface jfd_frame_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_word;
  logic        batch_first;
  logic        batch_last;

  modport source (output valid, output frame_word, output batch_first, output batch_last,
                  input ready);
  modport sink   (input valid, input frame_word, input batch_first, input batch_last,
                  output ready);
endinterface

// File: rtl/jfd_pads_if.sv
interface jfd_pads_if;
  logic        valid;
  logic        ready;
  logic [11:0] pad0_buttons;
  logic [11:0] pad1_buttons;

  modport source (output valid, output pad0_buttons, output pad1_buttons, input ready);
  modport sink   (input valid, input pad0_buttons, input pad1_buttons, output ready);
endinterface

// File: rtl/jfd_pad_lane.sv
module jfd_pad_lane
  import jfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lane_ctrl_t        ctrl,
  input  logic [BYTE_W-1:0] cur_byte,
  input  logic [PAD_W-1:0]  jamma_word,
  output logic [PAD_W-1:0]  word
);

  logic [PAD_W-1:0]  plain_word, plain_word_next;
  logic [PAD_W-1:0]  mux_word, mux_word_next;
  logic [BYTE_W-1:0] prev_byte, prev_byte_next;
  logic [BYTE_W-1:0] history, history_next;
  logic              seen, seen_next;

  logic [BYTE_W-1:0] prev_eff;
  logic              seen_eff;

  always_comb begin
    plain_word_next = plain_word;
    mux_word_next   = mux_word;
    prev_byte_next  = prev_byte;
    history_next    = history;
    seen_next       = seen;
    prev_eff        = ctrl.first ? '0 : prev_byte;
    seen_eff        = ctrl.first ? 1'b0 : seen;
    unique case (ctrl.mode)
      MODE_DIRECT: begin
        plain_word_next = db9_remap(cur_byte);
      end
      MODE_WIDE: begin
        plain_word_next = jamma_word;
      end
      MODE_MD: begin
        seen_next      = seen_eff;
        prev_byte_next = cur_byte;
        priority if ((prev_eff & MD_EXTRA_MASK) == MD_EXTRA_MASK) begin
          // six-button extra frame: X Y L and select
          mux_word_next[10:8] = cur_byte[7:5];
          mux_word_next[6]    = cur_byte[4];
          seen_next           = 1'b1;
        end else if ((prev_eff & MD_PHASE_MASK) == MD_PHASE_MASK) begin
          mux_word_next[5]  = cur_byte[3];
          mux_word_next[11] = cur_byte[2];
          seen_next         = 1'b1;
        end else if ((cur_byte & MD_PHASE_MASK) == MD_PHASE_MASK) begin
          mux_word_next[7] = cur_byte[2];
          mux_word_next[4] = cur_byte[3];
          seen_next        = 1'b1;
        end else if (history != '0) begin
          mux_word_next[3:0] = cur_byte[7:4];
          mux_word_next[5]   = cur_byte[3];
        end else begin
          plain_word_next = db9_remap(cur_byte);
        end
        if (ctrl.last) begin
          history_next = {history[BYTE_W-2:0], seen_next};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (ctrl.mode)
      MODE_MD:   word = (history_next != '0) ? mux_word_next : plain_word_next;
      MODE_NONE: word = '0;
      default:   word = plain_word_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plain_word <= '0;
      mux_word   <= '0;
      prev_byte  <= '0;
      history    <= '0;
      seen       <= 1'b0;
    end else if (ctrl.enable) begin
      plain_word <= plain_word_next;
      mux_word   <= mux_word_next;
      prev_byte  <= prev_byte_next;
      history    <= history_next;
      seen       <= seen_next;
    end
  end

endmodule

// File: rtl/joypad_frame_decoder.sv
// Two-pad frame decoder.
// frame: one item per 32-bit active-low shift-register frame with its batch
//   flags; pad 1 sits in bits 15:8, pad 0 in bits 23:16.
// pads: one item per frame carrying both 12-bit pad words.
// cfg: writes pad_mode (DB9, JAMMA, Mega Drive or unused); always ready. Write it only
//   while no frame is in flight.
// A frame passes the input register, then the decode into the result register,
//   before it is presented on pads; a stall holds it in the input register.
// Throughput: one frame per clock while pads.ready holds. Per-pad history is read
//   and updated in the single decode step between the two registers, so frames
//   follow back to back.
// Reset clears the mode to DB9, all pad history and both pipeline stages.
// When the receiver stalls, the result is held, one more frame waits in the
//   input register, and frame.ready then drops until pads.ready returns.
module joypad_frame_decoder
  import jfd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  jfd_cfg_if.sink    cfg,
  jfd_frame_if.sink  frame,
  jfd_pads_if.source pads
);

  pad_mode_t   mode;
  logic        in_valid;
  logic [31:0] in_word;
  logic        in_first;
  logic        in_last;
  logic        out_valid;
  logic [PAD_W-1:0] out_pad0;
  logic [PAD_W-1:0] out_pad1;

  logic        advance;
  logic [31:0] data;
  lane_ctrl_t  ctrl;
  logic [PAD_W-1:0] word0;
  logic [PAD_W-1:0] word1;

  assign cfg.ready   = 1'b1;
  assign advance     = in_valid && (!out_valid || pads.ready);
  assign frame.ready = !in_valid || advance;

  assign data        = ~in_word;
  assign ctrl.enable = advance;
  assign ctrl.mode   = mode;
  assign ctrl.first  = in_first;
  assign ctrl.last   = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DIRECT;
    end else if (cfg.valid && cfg.ready) begin
      mode <= pad_mode_t'(cfg.pad_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame.valid && frame.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      in_word  <= frame.frame_word;
      in_first <= frame.batch_first;
      in_last  <= frame.batch_last;
    end
  end

  jfd_pad_lane u_lane0 (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cur_byte   (data[23:16]),
    .jamma_word (jamma_pad0(data)),
    .word       (word0)
  );

  jfd_pad_lane u_lane1 (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cur_byte   (data[15:8]),
    .jamma_word (jamma_pad1(data)),
    .word       (word1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pads.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pad0 <= word0;
      out_pad1 <= word1;
    end
  end

  assign pads.valid        = out_valid;
  assign pads.pad0_buttons = out_pad0;
  assign pads.pad1_buttons = out_pad1;

  // Unused mode yields an all-zero result
  a_mode_none_zero: assert property (@(posedge clk) disable iff (rst)
    advance && mode == MODE_NONE |=> pads.pad0_buttons == '0 && pads.pad1_buttons == '0)
    else $error("unused mode gave a nonzero result");

  // Both stages full and the receiver stalled: take no new frame
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !pads.ready |-> !frame.ready)
    else $error("frame accepted while both stages are full");

  // A fresh result always comes from a frame held in the input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid))
    else $error("result appeared with no frame");

  // A held result stays put while the receiver stalls
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pads.ready |=> out_valid && $stable(out_pad0) && $stable(out_pad1))
    else $error("stalled result changed");

endmodule
